/* design/gccc_pkg.sv */
//------------------------------------------------------------------------------
// GC content codon counter package
// Item types, character codes and stop codons shared by the counter modules.
//------------------------------------------------------------------------------
`default_nettype none

package gccc_pkg;

	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_G = 8'h47;
	localparam logic [7:0] CHAR_N = 8'h4E;

	localparam logic [23:0] STOP_TAA = 24'h544141;
	localparam logic [23:0] STOP_TAG = 24'h544147;
	localparam logic [23:0] STOP_TGA = 24'h544741;

	localparam int MIN_CDS_LEN = 3;
	localparam int CODON_LEN = 3;

	localparam logic MODE_GENOME = 1'b0;
	localparam logic MODE_CODING = 1'b1;

	typedef struct packed {
		logic [7:0] base;
		logic       last_base;
	} in_item_t;

	typedef struct packed {
		logic [23:0] seq_count;
		logic [23:0] good_count;
		logic [39:0] total_len;
		logic [39:0] gc_total;
		logic [39:0] n_total;
		logic [39:0] gc_first;
		logic [39:0] gc_second;
		logic [39:0] gc_third;
		logic        seq_accepted;
		logic        saturated;
	} out_item_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic inc_base;
		logic inc_gc;
		logic inc_n;
		logic accept;
		logic sat;
	} seq_ctrl_t;

endpackage

`default_nettype wire

/* design/gccc_sat_add.sv */
//------------------------------------------------------------------------------
// Saturating adder
// Adds an addend of any width to a counter and clamps at the counter's maximum.
//------------------------------------------------------------------------------
`default_nettype none

module gccc_sat_add #(
	parameter int W  = 40,
	parameter int BW = 32
) (
	input  wire logic [W-1:0]  a,
	input  wire logic [BW-1:0] b,
	output logic      [W-1:0]  y,
	output logic               hit_max
);

	localparam int SW = ((W > BW) ? W : BW) + 1;
	localparam logic [SW-1:0] MAX_W = SW'({W{1'b1}});

	logic [SW-1:0] sum;

	assign sum     = SW'(a) + SW'(b);
	assign hit_max = (b != '0) && (sum >= MAX_W);
	assign y       = (sum > MAX_W) ? {W{1'b1}} : sum[W-1:0];

endmodule

`default_nettype wire

/* design/gccc_seq_track.sv */
//------------------------------------------------------------------------------
// Per-sequence tracker
// Tracks length, codon phase, tail bases and per-position C/G counts of the
// current sequence and decides codon acceptance at the sequence end.
//------------------------------------------------------------------------------
`default_nettype none

module gccc_seq_track #(
	parameter int SEQ_LEN_BITS = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     take,
	input  wire logic                     drain,
	input  wire gccc_pkg::in_item_t       item,
	input  wire logic                     cds_mode,
	output gccc_pkg::seq_ctrl_t           ctrl_s2,
	output logic      [SEQ_LEN_BITS-1:0]  len_s2,
	output logic      [SEQ_LEN_BITS-1:0]  gc_s2,
	output logic      [SEQ_LEN_BITS-1:0]  trial_s2 [gccc_pkg::CODON_LEN]
);

	logic [1:0]              phase_q;
	logic [23:0]             tail_q;
	logic [SEQ_LEN_BITS-1:0] len_q;
	logic [SEQ_LEN_BITS-1:0] gc_q;
	logic [SEQ_LEN_BITS-1:0] trial_q  [gccc_pkg::CODON_LEN];
	logic [SEQ_LEN_BITS-1:0] trial_nx [gccc_pkg::CODON_LEN];
	logic [2:0]              trial_hit;

	logic                    is_gc;
	logic                    is_n;
	logic                    len_full;
	logic [SEQ_LEN_BITS-1:0] len_nx;
	logic [SEQ_LEN_BITS-1:0] gc_nx;
	logic [1:0]              phase_nx;
	logic [23:0]             tail_nx;
	logic                    stop;
	logic                    accept;
	logic                    sat;
	logic                    coding;

	assign is_gc    = (item.base == gccc_pkg::CHAR_C) || (item.base == gccc_pkg::CHAR_G);
	assign is_n     = (item.base == gccc_pkg::CHAR_N);
	assign coding   = (cds_mode == gccc_pkg::MODE_CODING);
	assign len_full = &len_q;
	assign len_nx   = len_full ? len_q : len_q + SEQ_LEN_BITS'(1);
	assign gc_nx    = (is_gc && !(&gc_q)) ? gc_q + SEQ_LEN_BITS'(1) : gc_q;
	assign phase_nx = (phase_q >= 2'd2) ? 2'd0 : phase_q + 2'd1;
	assign tail_nx  = {tail_q[15:0], item.base};
	assign stop     = (tail_nx == gccc_pkg::STOP_TAA) || (tail_nx == gccc_pkg::STOP_TAG)
		|| (tail_nx == gccc_pkg::STOP_TGA);
	assign accept   = coding && item.last_base && !len_full && (phase_nx == 2'd0) && stop
		&& (len_nx >= SEQ_LEN_BITS'(gccc_pkg::MIN_CDS_LEN));
	assign sat      = (&len_q[SEQ_LEN_BITS-1:1]) || (|trial_hit);

	for (genvar i = 0; i < gccc_pkg::CODON_LEN; i++) begin : g_pos
		logic inc;
		assign inc          = is_gc && (phase_q == 2'(i));
		assign trial_hit[i] = inc && (&trial_q[i][SEQ_LEN_BITS-1:1]);
		assign trial_nx[i]  = (inc && !(&trial_q[i])) ? trial_q[i] + SEQ_LEN_BITS'(1)
			: trial_q[i];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				trial_q[i] <= '0;
			end else if (take) begin
				trial_q[i] <= item.last_base ? '0 : trial_nx[i];
			end
		end

		always_ff @(posedge clk) begin
			if (take) begin
				trial_s2[i] <= trial_nx[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			tail_q  <= '0;
			len_q   <= '0;
			gc_q    <= '0;
			ctrl_s2 <= '0;
		end else begin
			if (take) begin
				phase_q <= item.last_base ? 2'd0 : phase_nx;
				tail_q  <= item.last_base ? 24'd0 : tail_nx;
				len_q   <= item.last_base ? '0 : len_nx;
				gc_q    <= item.last_base ? '0 : gc_nx;
				ctrl_s2.valid    <= 1'b1;
				ctrl_s2.last     <= item.last_base;
				ctrl_s2.inc_base <= !coding;
				ctrl_s2.inc_gc   <= !coding && is_gc;
				ctrl_s2.inc_n    <= !coding && is_n;
				ctrl_s2.accept   <= accept;
				ctrl_s2.sat      <= sat;
			end else if (drain) begin
				ctrl_s2.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			len_s2 <= len_nx;
			gc_s2  <= gc_nx;
		end
	end

endmodule

`default_nettype wire

/* design/gccc_totals.sv */
//------------------------------------------------------------------------------
// Running totals
// Holds the saturating totals over all sequences and the result register.
//------------------------------------------------------------------------------
`default_nettype none

module gccc_totals #(
	parameter int SEQ_LEN_BITS   = 32,
	parameter int TOTAL_BITS     = 40,
	parameter int SEQ_COUNT_BITS = 24
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     go,
	input  wire gccc_pkg::seq_ctrl_t      ctrl,
	input  wire logic [SEQ_LEN_BITS-1:0]  len,
	input  wire logic [SEQ_LEN_BITS-1:0]  gc,
	input  wire logic [SEQ_LEN_BITS-1:0]  trial [gccc_pkg::CODON_LEN],
	input  wire logic                     result_ready,
	output logic                          result_valid,
	output gccc_pkg::out_item_t           result_data
);

	localparam int NTOT = 6;

	logic [SEQ_COUNT_BITS-1:0] seq_q, good_q, seq_nx, good_nx;
	logic [TOTAL_BITS-1:0]     tot_q  [NTOT];
	logic [TOTAL_BITS-1:0]     tot_nx [NTOT];
	logic [SEQ_LEN_BITS-1:0]   addend [NTOT];
	logic [NTOT-1:0]           tot_hit;
	logic                      seq_hit, good_hit;
	logic                      sat_q, sat_nx;
	logic [63:0]               seq_w, good_w;
	logic [63:0]               tot_w  [NTOT];

	always_comb begin
		addend[0] = ctrl.inc_base ? SEQ_LEN_BITS'(1) : (ctrl.accept ? len : '0);
		addend[1] = ctrl.inc_gc ? SEQ_LEN_BITS'(1) : (ctrl.accept ? gc : '0);
		addend[2] = ctrl.inc_n ? SEQ_LEN_BITS'(1) : '0;
		addend[3] = ctrl.accept ? trial[0] : '0;
		addend[4] = ctrl.accept ? trial[1] : '0;
		addend[5] = ctrl.accept ? trial[2] : '0;
	end

	for (genvar i = 0; i < NTOT; i++) begin : g_tot
		gccc_sat_add #(.W(TOTAL_BITS), .BW(SEQ_LEN_BITS)) u_add (
			.a       (tot_q[i]),
			.b       (addend[i]),
			.y       (tot_nx[i]),
			.hit_max (tot_hit[i])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tot_q[i] <= '0;
			end else if (go) begin
				tot_q[i] <= tot_nx[i];
			end
		end

		assign tot_w[i] = 64'(tot_nx[i]);
	end

	gccc_sat_add #(.W(SEQ_COUNT_BITS), .BW(1)) u_seq_add (
		.a       (seq_q),
		.b       (ctrl.last),
		.y       (seq_nx),
		.hit_max (seq_hit)
	);

	gccc_sat_add #(.W(SEQ_COUNT_BITS), .BW(1)) u_good_add (
		.a       (good_q),
		.b       (ctrl.accept),
		.y       (good_nx),
		.hit_max (good_hit)
	);

	assign sat_nx = sat_q || ctrl.sat || seq_hit || good_hit || (|tot_hit);
	assign seq_w  = 64'(seq_nx);
	assign good_w = 64'(good_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= '0;
			good_q       <= '0;
			sat_q        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (go) begin
				seq_q  <= seq_nx;
				good_q <= good_nx;
				sat_q  <= sat_nx;
			end
			if (go && ctrl.last) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && ctrl.last) begin
			result_data.seq_count    <= seq_w[23:0];
			result_data.good_count   <= good_w[23:0];
			result_data.total_len    <= tot_w[0][39:0];
			result_data.gc_total     <= tot_w[1][39:0];
			result_data.n_total      <= tot_w[2][39:0];
			result_data.gc_first     <= tot_w[3][39:0];
			result_data.gc_second    <= tot_w[4][39:0];
			result_data.gc_third     <= tot_w[5][39:0];
			result_data.seq_accepted <= ctrl.accept;
			result_data.saturated    <= sat_nx;
		end
	end

endmodule

`default_nettype wire

/* design/gc_content_codon_counter.sv */
//------------------------------------------------------------------------------
// GC content and codon position counter
// A sequence end reaches the result via the input, tracker and result registers.
// Throughput: one base per cycle barring stalls; bases flow while a result waits.
// The result register stalls the pipeline only when a second result is due.
// Reset clears all counters, per-sequence state and the mode register (genome mode).
//------------------------------------------------------------------------------
`default_nettype none

module gc_content_codon_counter #(
	parameter int SEQ_LEN_BITS   = 32,
	parameter int TOTAL_BITS     = 40,
	parameter int SEQ_COUNT_BITS = 24
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                base_valid,
	output logic                     base_ready,
	input  wire gccc_pkg::in_item_t  base_data,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output gccc_pkg::out_item_t      result_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_data
);

	logic                    cds_mode_q;
	logic                    valid_s1;
	gccc_pkg::in_item_t      item_s1;
	gccc_pkg::seq_ctrl_t     ctrl_s2;
	logic [SEQ_LEN_BITS-1:0] len_s2;
	logic [SEQ_LEN_BITS-1:0] gc_s2;
	logic [SEQ_LEN_BITS-1:0] trial_s2 [gccc_pkg::CODON_LEN];
	logic                    out_free;
	logic                    s2_go;
	logic                    s1_go;

	assign cfg_ready  = 1'b1;
	assign out_free   = !result_valid || result_ready;
	assign s2_go      = ctrl_s2.valid && (!ctrl_s2.last || out_free);
	assign s1_go      = valid_s1 && (!ctrl_s2.valid || s2_go);
	assign base_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cds_mode_q <= gccc_pkg::MODE_GENOME;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cds_mode_q <= cfg_data;
			end
			if (base_ready) begin
				valid_s1 <= base_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (base_valid && base_ready) begin
			item_s1 <= base_data;
		end
	end

	gccc_seq_track #(.SEQ_LEN_BITS(SEQ_LEN_BITS)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (s1_go),
		.drain    (s2_go),
		.item     (item_s1),
		.cds_mode (cds_mode_q),
		.ctrl_s2  (ctrl_s2),
		.len_s2   (len_s2),
		.gc_s2    (gc_s2),
		.trial_s2 (trial_s2)
	);

	gccc_totals #(
		.SEQ_LEN_BITS   (SEQ_LEN_BITS),
		.TOTAL_BITS     (TOTAL_BITS),
		.SEQ_COUNT_BITS (SEQ_COUNT_BITS)
	) u_totals (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (s2_go),
		.ctrl         (ctrl_s2),
		.len          (len_s2),
		.gc           (gc_s2),
		.trial        (trial_s2),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result_data  (result_data)
	);

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
//------------------------------------------------------------------------------
// GC content codon counter testbench
// Feeds the counter directed and random nucleotide streams in genome and coding
// mode, with random idle cycles on both channels and one long result hold-off,
// and checks every result against a cycle-free model of the running totals.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

class gc_tally_tracker;

	localparam longint unsigned LEN_MAX = 64'hFFFF_FFFF;
	localparam longint unsigned TOT_MAX = 64'hFF_FFFF_FFFF;
	localparam longint unsigned CNT_MAX = 64'hFF_FFFF;

	logic                  mode;
	bit [1:0]              phase;
	bit [23:0]             tail;
	longint unsigned       seq_len;
	longint unsigned       trial_gc[3];
	longint unsigned       seqs;
	longint unsigned       goods;
	longint unsigned       totals[6];
	bit                    sat;
	gccc_pkg::out_item_t   tally_due_q[$];
	int                    errors;

	function new();
		mode = gccc_pkg::MODE_GENOME;
		phase = 0;
		tail = 0;
		seq_len = 0;
		seqs = 0;
		goods = 0;
		sat = 0;
		errors = 0;
		foreach (trial_gc[i]) trial_gc[i] = 0;
		foreach (totals[i]) totals[i] = 0;
	endfunction

	function longint unsigned clip_add(longint unsigned a, longint unsigned b,
			longint unsigned max);
		if (a > max) a = max;
		if (b > max - a) begin
			sat = 1;
			return max;
		end
		if (a + b == max && b != 0) sat = 1;
		return a + b;
	endfunction

	function void set_mode(logic m);
		mode = m;
	endfunction

	function int pending();
		return tally_due_q.size();
	endfunction

	function void note_base(gccc_pkg::in_item_t it);
		bit                  is_gc;
		bit                  len_full;
		bit                  stop;
		bit                  accepted;
		longint unsigned     sum;
		gccc_pkg::out_item_t r;
		is_gc = (it.base == gccc_pkg::CHAR_C) || (it.base == gccc_pkg::CHAR_G);
		accepted = 0;
		if (mode == gccc_pkg::MODE_GENOME) begin
			totals[0] = clip_add(totals[0], 1, TOT_MAX);
			if (is_gc) totals[1] = clip_add(totals[1], 1, TOT_MAX);
			else if (it.base == gccc_pkg::CHAR_N) totals[2] = clip_add(totals[2], 1, TOT_MAX);
		end
		if (is_gc) trial_gc[phase] = clip_add(trial_gc[phase], 1, LEN_MAX);
		phase = (phase == 2) ? 2'd0 : phase + 2'd1;
		tail = {tail[15:0], it.base};
		len_full = (seq_len >= LEN_MAX);
		seq_len = clip_add(seq_len, 1, LEN_MAX);
		if (!it.last_base) return;
		seqs = clip_add(seqs, 1, CNT_MAX);
		if (mode == gccc_pkg::MODE_CODING) begin
			stop = (tail == gccc_pkg::STOP_TAA) || (tail == gccc_pkg::STOP_TAG)
				|| (tail == gccc_pkg::STOP_TGA);
			if (!len_full && seq_len >= gccc_pkg::MIN_CDS_LEN && phase == 0 && stop) begin
				accepted = 1;
				goods = clip_add(goods, 1, CNT_MAX);
				totals[0] = clip_add(totals[0], seq_len, TOT_MAX);
				sum = trial_gc[0] + trial_gc[1] + trial_gc[2];
				totals[1] = clip_add(totals[1], sum, TOT_MAX);
				for (int i = 0; i < 3; i++)
					totals[3 + i] = clip_add(totals[3 + i], trial_gc[i], TOT_MAX);
			end
		end
		phase = 0;
		tail = 0;
		seq_len = 0;
		foreach (trial_gc[i]) trial_gc[i] = 0;
		r.seq_count = seqs[23:0];
		r.good_count = goods[23:0];
		r.total_len = totals[0][39:0];
		r.gc_total = totals[1][39:0];
		r.n_total = totals[2][39:0];
		r.gc_first = totals[3][39:0];
		r.gc_second = totals[4][39:0];
		r.gc_third = totals[5][39:0];
		r.seq_accepted = accepted;
		r.saturated = sat;
		tally_due_q.push_back(r);
	endfunction

	function void match_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			errors++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	function void check_tally(gccc_pkg::out_item_t got);
		gccc_pkg::out_item_t want;
		if (tally_due_q.size() == 0) begin
			errors++;
			$error("result item with no sequence end pending");
			return;
		end
		want = tally_due_q.pop_front();
		match_field("seq_count", 64'(want.seq_count), 64'(got.seq_count));
		match_field("good_count", 64'(want.good_count), 64'(got.good_count));
		match_field("total_len", 64'(want.total_len), 64'(got.total_len));
		match_field("gc_total", 64'(want.gc_total), 64'(got.gc_total));
		match_field("n_total", 64'(want.n_total), 64'(got.n_total));
		match_field("gc_first", 64'(want.gc_first), 64'(got.gc_first));
		match_field("gc_second", 64'(want.gc_second), 64'(got.gc_second));
		match_field("gc_third", 64'(want.gc_third), 64'(got.gc_third));
		match_field("seq_accepted", 64'(want.seq_accepted), 64'(got.seq_accepted));
		match_field("saturated", 64'(want.saturated), 64'(got.saturated));
	endfunction

endclass

module tb_top;

	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 10;
	localparam int PHASE_ITEMS = 107;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                base_valid = 1'b0;
	logic                base_ready;
	gccc_pkg::in_item_t  base_data = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	gccc_pkg::out_item_t result_data;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                cfg_data = 1'b0;

	bit        no_idle = 1'b0;
	bit        hold_req = 1'b0;
	int        offered = 0;
	logic [7:0] strand_q[$];

	gc_tally_tracker tracker = new();

	gc_content_codon_counter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.base_valid   (base_valid),
		.base_ready   (base_ready),
		.base_data    (base_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (result_valid && result_ready) tracker.check_tally(result_data);
		if (base_valid && base_ready) tracker.note_base(base_data);
	end

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				result_ready <= 1'b1;
			end else if (stall > 0) begin
				result_ready <= 1'b0;
				stall--;
			end else begin
				stall = pick_gap();
				result_ready <= (stall == 0);
				if (stall > 0) stall--;
			end
		end
	end

	task automatic send_base(input logic [7:0] b, input logic last);
		gccc_pkg::in_item_t it;
		int                 gap;
		it.base = b;
		it.last_base = last;
		gap = pick_gap();
		if (gap > 0) begin
			base_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		base_data <= it;
		base_valid <= 1'b1;
		do @(posedge clk); while (!base_ready);
		offered++;
		@(negedge clk);
	endtask

	task automatic send_strand(input bit with_last);
		for (int i = 0; i < strand_q.size(); i++)
			send_base(strand_q[i], with_last && (i == strand_q.size() - 1));
		strand_q.delete();
	endtask

	task automatic load_text(input string s);
		for (int i = 0; i < s.len(); i++) strand_q.push_back(s[i]);
	endtask

	task automatic settle();
		base_valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_data <= m;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_mode(m);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] rand_base();
		string nts;
		string low;
		nts = "ACGT";
		low = "acgtn";
		case ($urandom_range(0, 19))
			0: return 8'($urandom_range(0, 255));
			1: return low[$urandom_range(0, 4)];
			2: return gccc_pkg::CHAR_N;
			default: return nts[$urandom_range(0, 3)];
		endcase
	endfunction

	task automatic add_codons(input int n);
		repeat (3 * n) strand_q.push_back(rand_base());
	endtask

	task automatic add_stop();
		case ($urandom_range(0, 2))
			0: load_text("TAA");
			1: load_text("TAG");
			default: load_text("TGA");
		endcase
	endtask

	task automatic make_strand(input bit short_only);
		int kind;
		kind = short_only ? 9 : $urandom_range(0, 9);
		case (kind)
			6: repeat ($urandom_range(1, 12)) strand_q.push_back(8'($urandom_range(0, 255)));
			7: begin
				add_codons($urandom_range(0, 7));
				add_stop();
				if ($urandom_range(0, 1)) void'(strand_q.pop_back());
				else strand_q.push_back(rand_base());
			end
			8: begin
				add_codons($urandom_range(0, 7));
				add_codons(1);
			end
			9: repeat ($urandom_range(1, 3)) strand_q.push_back(rand_base());
			default: begin
				add_codons($urandom_range(0, 7));
				add_stop();
			end
		endcase
	endtask

	task automatic run_phase(input int n, input bit short_only);
		int start;
		start = offered;
		while (offered - start < n) begin
			make_strand(short_only);
			send_strand(1'b1);
		end
		if (!short_only && $urandom_range(0, 1)) begin
			add_codons(1);
			repeat ($urandom_range(0, 2)) strand_q.push_back(rand_base());
			send_strand(1'b0);
		end
	endtask

	initial begin
		logic phase_mode[8];
		phase_mode = '{gccc_pkg::MODE_CODING, gccc_pkg::MODE_GENOME, gccc_pkg::MODE_CODING,
			gccc_pkg::MODE_CODING, gccc_pkg::MODE_GENOME, gccc_pkg::MODE_CODING,
			gccc_pkg::MODE_GENOME, gccc_pkg::MODE_CODING};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_mode(gccc_pkg::MODE_GENOME);
		load_text("CGNAT");
		send_strand(1'b1);
		load_text("cgn");
		strand_q.push_back(8'h00);
		strand_q.push_back(8'hFF);
		send_strand(1'b1);
		settle();

		write_mode(gccc_pkg::MODE_CODING);
		load_text("GCCTAG");
		send_strand(1'b1);
		load_text("TGA");
		send_strand(1'b1);
		load_text("GA");
		send_strand(1'b1);
		load_text("CTAA");
		send_strand(1'b1);
		settle();

		for (int p = 0; p < 8; p++) begin
			write_mode(phase_mode[p]);
			no_idle = (p == 2);
			if (p == 5) hold_req = 1'b1;
			run_phase(PHASE_ITEMS, p == 5);
			settle();
		end

		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

/* sim.f */
design/gccc_pkg.sv
design/gccc_sat_add.sv
design/gccc_seq_track.sv
design/gccc_totals.sv
design/gc_content_codon_counter.sv
tb/sv/tb_top.sv
